// File: sv/pbrs_pkg.sv
// Package: constants and controller/datapath command and status types.
package pbrs_pkg;
  localparam int unsigned POSITIONS_DEF = 64;
  localparam int unsigned BYTE_VALUES   = 256;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned DIST_W        = 9;
  localparam int unsigned SCORE_W       = 24;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned QUOT_W        = 25;
  localparam int unsigned DIVSTEP_W     = 6;
  localparam logic [31:0] THRESH_RESET  = 32'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef struct packed {
    logic clr_wr;     // write zero at sweep address
    logic clr_adv;    // advance sweep address
    logic capture;    // latch input item
    logic rd_item;    // issue reads for item
    logic update;     // read-modify-write, start divide setup
    logic div_step;   // one restoring division step
    logic finish;     // form score into output register
    logic halve_rd;   // read count at halving address
    logic halve_wr;   // write halved count, advance
  } pbrs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pos_ok;
    logic do_halve;
    logic div_last;
    logic halve_last;
  } pbrs_sts_t;
endpackage

// File: sv/pbrs_in_if.sv
// Input channel interface: position and byte item.
interface pbrs_in_if;
  logic                        valid;
  logic                        ready;
  logic [pbrs_pkg::POS_W-1:0]  position;
  logic [pbrs_pkg::BYTE_W-1:0] byte_value;
  modport source (output valid, position, byte_value, input ready);
  modport sink (input valid, position, byte_value, output ready);
endinterface

// File: sv/pbrs_out_if.sv
// Output channel interface: score item.
interface pbrs_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbrs_pkg::SCORE_W-1:0] score;
  modport source (output valid, score, input ready);
  modport sink (input valid, score, output ready);
endinterface

// File: sv/positional_byte_rarity_scorer_unit.sv
// Positional byte rarity scorer: top level.
// Accept to score: read, update, then 57 divide steps; an out-of-range position is scored zero at read.
// Items do not overlap: the next is accepted in idle after the score is taken; halving rewrites each byte value.
// The divide loop sets the rate: one restoring step per cycle over a 57-bit dividend.
// Reset: synchronous; a clearing pass over all POSITIONS*256 count entries zeroes all counts
// before the first item is accepted; threshold resets to 1024.
module positional_byte_rarity_scorer_unit #(
  parameter int unsigned POSITIONS = pbrs_pkg::POSITIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pbrs_in_if.sink     in_ch,
  pbrs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  pbrs_pkg::pbrs_cmd_t cmd;
  pbrs_pkg::pbrs_sts_t sts;
  logic [pbrs_pkg::POS_W-1:0] pos_cnt;
  logic clr_pos_last;

  // tracks sweep position count alongside the datapath address
  always_ff @(posedge clk) begin
    if (rst) pos_cnt <= '0;
    else if (cmd.clr_adv) pos_cnt <= pos_cnt + 1'b1;
  end
  assign clr_pos_last = (pos_cnt == pbrs_pkg::POS_W'(POSITIONS - 1));

  pbrs_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .clr_pos_last, .cmd, .sts);

  pbrs_datapath #(.POSITIONS(POSITIONS)) u_dp (
    .clk, .rst,
    .thr_we(cfg_we), .thr_wdata(cfg_wdata),
    .in_position(in_ch.position), .in_byte(in_ch.byte_value),
    .cmd, .sts, .score(out_ch.score));
endmodule

// File: sv/pbrs_ram.sv
// Generic single-port RAM with registered read.
module pbrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: sv/pbrs_datapath.sv
// Datapath: count memories, distinct/total memories, serial divider, halving sweep.
module pbrs_datapath #(
  parameter int unsigned POSITIONS = pbrs_pkg::POSITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          thr_we,
  input  logic [31:0]                   thr_wdata,
  input  logic [pbrs_pkg::POS_W-1:0]    in_position,
  input  logic [pbrs_pkg::BYTE_W-1:0]   in_byte,
  input  pbrs_pkg::pbrs_cmd_t           cmd,
  output pbrs_pkg::pbrs_sts_t           sts,
  output logic [pbrs_pkg::SCORE_W-1:0]  score
);
  localparam int unsigned PW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned CW = PW + pbrs_pkg::BYTE_W;
  localparam int unsigned CD = POSITIONS * pbrs_pkg::BYTE_VALUES;
  localparam int unsigned NUM_W = pbrs_pkg::DIST_W + pbrs_pkg::COUNT_W + pbrs_pkg::FRAC_W;
  localparam int unsigned PROD_W = NUM_W - pbrs_pkg::FRAC_W;

  logic [31:0] threshold;
  logic [pbrs_pkg::POS_W-1:0] pos_r;
  logic [pbrs_pkg::BYTE_W-1:0] byte_r, hv;
  logic [PW-1:0] clr_addr;
  logic [pbrs_pkg::DIST_W-1:0] dist_r;
  logic [NUM_W-1:0] num;
  logic [pbrs_pkg::COUNT_W-1:0] den;
  logic [pbrs_pkg::COUNT_W:0] rem;
  logic [pbrs_pkg::QUOT_W-1:0] quo;
  logic [pbrs_pkg::DIVSTEP_W-1:0] step;
  logic halve_flag, out_zero;

  logic c_we, d_we, t_we;
  logic [CW-1:0] c_addr;
  logic [PW-1:0] p_addr;
  logic [pbrs_pkg::COUNT_W-1:0] c_wd, c_rd, t_wd, t_rd;
  logic [pbrs_pkg::DIST_W-1:0] d_wd, d_rd;
  logic [pbrs_pkg::COUNT_W-1:0] cnt_new, tot_new, halved;
  logic [pbrs_pkg::DIST_W-1:0] dist_new;
  logic [pbrs_pkg::COUNT_W:0] trial;
  logic [pbrs_pkg::COUNT_W:0] rem_next;
  logic [pbrs_pkg::QUOT_W-1:0] quo_next;
  logic [CW-1:0] clr_c_addr;
  logic [pbrs_pkg::FRAC_W-1:0] frac_zero;
  logic [PROD_W-1:0] prod;

  assign frac_zero = '0;
  assign clr_c_addr = {clr_addr, hv};

  pbrs_ram #(.WIDTH(pbrs_pkg::COUNT_W), .DEPTH(CD)) u_cnt (
    .clk, .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));
  pbrs_ram #(.WIDTH(pbrs_pkg::DIST_W), .DEPTH(POSITIONS)) u_dist (
    .clk, .we(d_we), .addr(p_addr), .wdata(d_wd), .rdata(d_rd));
  pbrs_ram #(.WIDTH(pbrs_pkg::COUNT_W), .DEPTH(POSITIONS)) u_tot (
    .clk, .we(t_we), .addr(p_addr), .wdata(t_wd), .rdata(t_rd));

  assign cnt_new  = (c_rd == pbrs_pkg::COUNT_MAX) ? c_rd : c_rd + 1'b1;
  assign tot_new  = (t_rd == pbrs_pkg::COUNT_MAX) ? t_rd : t_rd + 1'b1;
  assign dist_new = (c_rd == '0 && d_rd < pbrs_pkg::DIST_W'(pbrs_pkg::BYTE_VALUES))
                    ? d_rd + 1'b1 : d_rd;
  assign halved   = c_rd >> 1;
  assign trial    = {rem[pbrs_pkg::COUNT_W-1:0], num[NUM_W-1]} - {1'b0, den};
  assign prod     = PROD_W'(dist_new) * PROD_W'(cnt_new);
  assign rem_next = trial[pbrs_pkg::COUNT_W] ? {rem[pbrs_pkg::COUNT_W-1:0], num[NUM_W-1]}
                                             : trial;
  // quotient bit 24, above the 24 score bits, only flags saturation
  assign quo_next = {quo[pbrs_pkg::QUOT_W-2:0], !trial[pbrs_pkg::COUNT_W]}
                    | {quo[pbrs_pkg::QUOT_W-1], {(pbrs_pkg::QUOT_W-1){1'b0}}};

  always_comb begin
    c_we = 1'b0; d_we = 1'b0; t_we = 1'b0;
    c_addr = {pos_r[PW-1:0], byte_r};
    p_addr = pos_r[PW-1:0];
    c_wd = cnt_new; d_wd = dist_new; t_wd = tot_new;
    if (cmd.clr_wr) begin
      c_we = 1'b1; c_addr = clr_c_addr; c_wd = '0;
      d_we = (hv == '0); t_we = (hv == '0);
      p_addr = clr_addr; d_wd = '0; t_wd = '0;
    end else if (cmd.update) begin
      c_we = 1'b1; d_we = 1'b1; t_we = 1'b1;
    end else if (cmd.halve_rd) begin
      c_addr = {pos_r[PW-1:0], hv};
    end else if (cmd.halve_wr) begin
      c_we = 1'b1; c_addr = {pos_r[PW-1:0], hv}; c_wd = halved;
      d_we = 1'b1; d_wd = dist_r;
      if (c_rd == 32'd1 && dist_r != '0) d_wd = dist_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= pbrs_pkg::THRESH_RESET;
      clr_addr <= '0;
      hv <= '0;
    end else begin
      if (thr_we) threshold <= thr_wdata;
      if (cmd.clr_wr) hv <= hv + 1'b1;
      if (cmd.clr_adv) clr_addr <= clr_addr + 1'b1;
      if (cmd.update) hv <= '0;
      if (cmd.halve_wr) hv <= hv + 1'b1;
    end
    if (cmd.capture) begin
      pos_r <= in_position;
      byte_r <= in_byte;
    end
    if (cmd.update) begin
      dist_r <= dist_new;
      num <= {prod, frac_zero};
      den <= tot_new;
      rem <= '0;
      quo <= '0;
      step <= '0;
      halve_flag <= (tot_new != t_rd) && (tot_new == threshold);
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      num <= num << 1;
      step <= step + 1'b1;
    end
    if (cmd.halve_wr && c_rd == 32'd1 && dist_r != '0) dist_r <= dist_r - 1'b1;
    if (cmd.capture) out_zero <= (in_position >= pbrs_pkg::POS_W'(POSITIONS));
    // on the divide path finish comes with the last divide step, so take the quotient after it
    if (cmd.finish) begin
      if (out_zero) score <= '0;
      else if (quo_next[pbrs_pkg::QUOT_W-1]) score <= pbrs_pkg::SCORE_MAX;
      else score <= quo_next[pbrs_pkg::SCORE_W-1:0];
    end
  end

  // division runs NUM_W steps; quotient can grow past 24 bits, sticky top bit saturates
  assign sts.clr_last   = (hv == '1);
  assign sts.pos_ok     = !out_zero;
  assign sts.do_halve   = halve_flag;
  assign sts.div_last   = (step == pbrs_pkg::DIVSTEP_W'(NUM_W - 1));
  assign sts.halve_last = (hv == '1);
endmodule

// File: sv/pbrs_ctrl.sv
// Controller: clear sweep, item sequencing, divide and halving steps.
module pbrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                clr_pos_last,
  output pbrs_pkg::pbrs_cmd_t cmd,
  input  pbrs_pkg::pbrs_sts_t sts
);
  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_UPD, S_DIV, S_HRD, S_HWR
  } state_t;
  state_t state;
  logic busy_out;

  assign in_ready  = (state == S_IDLE) && !busy_out;
  assign out_valid = busy_out;

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.clr_adv = sts.clr_last;
      end
      S_IDLE:  cmd.capture = in_valid && in_ready;
      S_READ:  cmd.rd_item = 1'b1;
      S_UPD:   cmd.update = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_HRD:   cmd.halve_rd = 1'b1;
      S_HWR:   cmd.halve_wr = 1'b1;
      default: cmd = '0;
    endcase
    if (state == S_DIV && sts.div_last) cmd.finish = 1'b1;
    if (state == S_READ && !sts.pos_ok) cmd.finish = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy_out <= 1'b0;
    end else begin
      if (busy_out && out_ready) busy_out <= 1'b0;
      case (state)
        S_CLEAR: if (sts.clr_last && clr_pos_last) state <= S_IDLE;
        S_IDLE:  if (in_valid && in_ready) state <= S_READ;
        S_READ:  if (sts.pos_ok) state <= S_UPD;
                 else begin
                   state <= S_IDLE;
                   busy_out <= 1'b1;
                 end
        S_UPD:   state <= S_DIV;
        S_DIV:   if (sts.div_last) begin
                   busy_out <= 1'b1;
                   state <= sts.do_halve ? S_HRD : S_IDLE;
                 end
        S_HRD:   state <= S_HWR;
        S_HWR:   state <= sts.halve_last ? S_IDLE : S_HRD;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
